@@ hw/rtl/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP responder package
// Shared types and constants for the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_SEND   = 2'd2;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_REQ    = 2'd1;
  localparam logic [1:0] KIND_ANSWER = 2'd2;

  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_OWN_MAC = 2'd1;
  localparam logic [1:0] REG_TX_EN   = 2'd2;

  localparam logic [4:0]  PKT_LEN = 5'd28;
  localparam logic [47:0] HDR_OK  = 48'h000108000604;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [31:0] query_ip;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [47:0] answer_mac;
    logic        answer_hit;
  } out_item_t;

  // Job handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_REPLY,
    JOB_REQUEST,
    JOB_ANSWER
  } job_kind_t;

  typedef struct packed {
    job_kind_t   jkind;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic [47:0] amac;
    logic        ahit;
  } job_t;

endpackage

@@ hw/rtl/arp_if.sv @@
// ----------------------------------------------------------------------------
// ARP stream interface
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface arp_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/arp_front.sv @@
// ----------------------------------------------------------------------------
// ARP front end
// Parses received bytes, maintains the cache and issues jobs to the back end.
// ----------------------------------------------------------------------------
module arp_front #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  arp_pkg::in_item_t in_data,
  input  logic [31:0]       own_ip,
  input  logic              transmit_enable,
  output logic              job_valid,
  input  logic              job_full,
  output arp_pkg::job_t     job
);

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [4:0]  byte_position;
  logic [63:0] header_words;
  logic [47:0] sender_mac_held;
  logic [31:0] sender_ip_held;
  logic [31:0] target_ip_held;
  logic [31:0] cache_ip  [CACHE_ENTRIES];
  logic [47:0] cache_mac [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] cache_valid;
  logic [IW-1:0] victim_pointer;

  logic          acc;
  logic [31:0]   sip;
  logic [31:0]   sr_ip;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          pkt_done;
  logic [IW-1:0] wr_idx;
  logic [63:0]   hdr_now;
  logic [31:0]   tip_now;

  // Accept only when the queue has room for a possible job.
  assign in_ready = !job_full;
  assign acc = in_valid && in_ready;

  // Values as of the 28th byte; the target IP includes the current byte.
  assign sip = sender_ip_held;
  assign hdr_now = header_words;
  assign tip_now = {target_ip_held[23:0], in_data.data_byte};
  assign pkt_done = in_data.mode == arp_pkg::MODE_BYTE &&
                    byte_position == arp_pkg::PKT_LEN - 5'd1 &&
                    hdr_now[63:16] == arp_pkg::HDR_OK;

  // Parallel cache search.
  assign sr_ip = (in_data.mode == arp_pkg::MODE_BYTE) ? sip : in_data.query_ip;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (cache_valid[i] && cache_ip[i] == sr_ip) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end
  assign wr_idx = hit ? hit_idx : victim_pointer;

  // Parser and cache state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_words <= '0;
      sender_mac_held <= '0;
      sender_ip_held <= '0;
      target_ip_held <= '0;
      cache_valid <= '0;
      victim_pointer <= '0;
    end else if (acc && in_data.mode == arp_pkg::MODE_BYTE) begin
      if (byte_position < 5'd8) begin
        header_words <= {header_words[55:0], in_data.data_byte};
      end else if (byte_position < 5'd14) begin
        sender_mac_held <= {sender_mac_held[39:0], in_data.data_byte};
      end else if (byte_position < 5'd18) begin
        sender_ip_held <= {sender_ip_held[23:0], in_data.data_byte};
      end else if (byte_position >= 5'd24 && byte_position < arp_pkg::PKT_LEN) begin
        target_ip_held <= tip_now;
      end
      if (in_data.last_byte) begin
        byte_position <= '0;
      end else if (byte_position < arp_pkg::PKT_LEN) begin
        byte_position <= byte_position + 5'd1;
      end
      if (pkt_done) begin
        cache_valid[wr_idx] <= 1'b1;
        if (!hit) begin
          victim_pointer <= (32'(victim_pointer) == CACHE_ENTRIES - 1) ? '0
                            : victim_pointer + IW'(1);
        end
      end
    end
  end

  // Cache payload stores.
  always_ff @(posedge clk) begin
    if (acc && pkt_done) begin
      cache_ip[wr_idx] <= sip;
      cache_mac[wr_idx] <= sender_mac_held;
    end
  end

  // Job issue.
  always_comb begin
    job_valid = 1'b0;
    job = '0;
    job.tmac = sender_mac_held;
    job.tip = in_data.mode == arp_pkg::MODE_BYTE ? sip : in_data.query_ip;
    job.amac = hit ? cache_mac[hit_idx] : '0;
    job.ahit = hit;
    case (in_data.mode)
      arp_pkg::MODE_BYTE: begin
        job.jkind = arp_pkg::JOB_REPLY;
        job_valid = acc && pkt_done && hdr_now[15:0] == 16'd1 &&
                    tip_now == own_ip && transmit_enable;
      end
      arp_pkg::MODE_LOOKUP: begin
        job.jkind = arp_pkg::JOB_ANSWER;
        job_valid = acc;
      end
      arp_pkg::MODE_SEND: begin
        // An outgoing request leaves the target MAC unknown.
        job.jkind = arp_pkg::JOB_REQUEST;
        job.tmac = '0;
        job_valid = acc && transmit_enable;
      end
      default: begin
        job.jkind = arp_pkg::JOB_ANSWER;
      end
    endcase
  end

endmodule

@@ hw/rtl/arp_queue.sv @@
// ----------------------------------------------------------------------------
// ARP job queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module arp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  arp_pkg::job_t push_data,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output arp_pkg::job_t head
);

  localparam int AW = $clog2(DEPTH);

  arp_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full = count == (AW+1)'(DEPTH);
  assign not_empty = count != '0;
  assign head = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/arp_back.sv @@
// ----------------------------------------------------------------------------
// ARP back end
// Serializes jobs into reply, request and lookup answer results.
// ----------------------------------------------------------------------------
module arp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_pop,
  input  arp_pkg::job_t      job,
  input  logic [31:0]        own_ip,
  input  logic [47:0]        own_mac,
  output logic               out_valid,
  input  logic               out_ready,
  output arp_pkg::out_item_t out_data
);

  logic [4:0]  idx;
  logic [7:0]  pbyte;
  logic [63:0] hdr;
  logic        is_ans;

  assign is_ans = job.jkind == arp_pkg::JOB_ANSWER;
  assign hdr = {arp_pkg::HDR_OK,
                (job.jkind == arp_pkg::JOB_REPLY) ? 16'd2 : 16'd1};

  // Byte at the current index of the outgoing payload.
  always_comb begin
    pbyte = 8'd0;
    if (idx < 5'd8) begin
      pbyte = hdr[8'd63 - {idx[2:0], 3'd0} -: 8];
    end else if (idx < 5'd14) begin
      pbyte = own_mac[8'd47 - 8'({idx - 5'd8, 3'd0}) -: 8];
    end else if (idx < 5'd18) begin
      pbyte = own_ip[8'd31 - 8'({idx - 5'd14, 3'd0}) -: 8];
    end else if (idx < 5'd24) begin
      pbyte = job.tmac[8'd47 - 8'({idx - 5'd18, 3'd0}) -: 8];
    end else begin
      pbyte = job.tip[8'd31 - 8'({idx - 5'd24, 3'd0}) -: 8];
    end
  end

  // Result drive from the queue head.
  assign out_valid = job_valid;
  always_comb begin
    out_data = '0;
    if (is_ans) begin
      out_data.kind = arp_pkg::KIND_ANSWER;
      out_data.out_last = 1'b1;
      out_data.answer_mac = job.amac;
      out_data.answer_hit = job.ahit;
    end else begin
      out_data.kind = (job.jkind == arp_pkg::JOB_REPLY) ? arp_pkg::KIND_REPLY
                      : arp_pkg::KIND_REQ;
      out_data.out_byte = pbyte;
      out_data.out_last = idx == arp_pkg::PKT_LEN - 5'd1;
    end
  end
  assign job_pop = job_valid && out_ready && out_data.out_last;

  // Byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (job_valid && out_ready) begin
      idx <= out_data.out_last ? 5'd0 : idx + 5'd1;
    end
  end

endmodule

@@ hw/rtl/arp_responder_with_cache_core.sv @@
// ----------------------------------------------------------------------------
// ARP responder with address cache
// Top level: front parser and cache, job queue, and payload serializer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per cycle unless stalled: a received ARP byte, a
//   cache lookup or a send command. out_ch carries results: 28 reply or request
//   payload bytes with out_last on the final one, or a single lookup answer.
//   The user must write configuration (own_ip, own_mac, transmit_enable)
//   through cfg_we/cfg_index/cfg_data while the block is idle; not enforced.
//   The front end takes one request per cycle while the queue is not full; the
//   cache search is a parallel compare over CACHE_ENTRIES entries in that cycle.
//   A lookup answer is stored in the queue and driven from its head; a reply or
//   request payload leaves one byte per cycle while out_ready is high.
//   Jobs wait in a four-entry queue; the input stalls only while it is full,
//   so a stalled receiver eventually holds back the input.
//   Reset clears the parser, the cache valid bits, the victim pointer, the
//   queue and the configuration registers.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_core #(
  parameter int CACHE_ENTRIES = 16
) (
  input logic        clk,
  input logic        rst,
  arp_if.sink        in_ch,
  arp_if.source      out_ch,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [47:0] cfg_data
);

  logic [31:0]   own_ip;
  logic [47:0]   own_mac;
  logic          transmit_enable;
  logic          push;
  logic          full;
  logic          not_empty;
  logic          pop;
  arp_pkg::job_t push_job;
  arp_pkg::job_t head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
      own_mac <= '0;
      transmit_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        arp_pkg::REG_OWN_IP:  own_ip <= cfg_data[31:0];
        arp_pkg::REG_OWN_MAC: own_mac <= cfg_data;
        arp_pkg::REG_TX_EN:   transmit_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  arp_front #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .own_ip(own_ip), .transmit_enable(transmit_enable),
    .job_valid(push), .job_full(full), .job(push_job)
  );

  arp_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_job), .full(full),
    .not_empty(not_empty), .pop(pop), .head(head)
  );

  arp_back u_back (
    .clk(clk), .rst(rst), .job_valid(not_empty), .job_pop(pop), .job(head),
    .own_ip(own_ip), .own_mac(own_mac),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder testbench
// Feeds received ARP frames, cache lookups and send commands through the
// request channel, predicts every result with a behavioral copy of the parser
// and cache, and checks the output stream field by field with random idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_SLOTS = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  arp_if #(.T(arp_pkg::in_item_t))  in_ch (clk);
  arp_if #(.T(arp_pkg::out_item_t)) out_ch (clk);

  arp_responder_with_cache_core #(.CACHE_ENTRIES(NUM_SLOTS)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [31:0] p_own_ip;
  logic [47:0] p_own_mac;
  logic        p_tx_en;
  logic [4:0]  p_pos;
  logic [63:0] p_hdr;
  logic [47:0] p_smac;
  logic [31:0] p_sip;
  logic [31:0] p_tip;
  logic [31:0] c_ip [NUM_SLOTS];
  logic [47:0] c_mac [NUM_SLOTS];
  logic        c_val [NUM_SLOTS];
  int          victim;

  arp_pkg::out_item_t pending_results[$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;

  // Directed rows: a lookup on the empty cache has a result known at a glance.
  typedef struct {
    arp_pkg::in_item_t  req;
    bit                 has_known;
    arp_pkg::out_item_t known;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int slot_of(input logic [31:0] ip);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (c_val[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  // Queues the 28 outgoing payload bytes of a reply or request.
  function automatic void queue_payload(input logic [15:0] op, input logic [47:0] tmac,
                                        input logic [31:0] tip, input logic [1:0] k);
    logic [223:0]       pay;
    arp_pkg::out_item_t r;
    pay = {arp_pkg::HDR_OK, op, p_own_mac, p_own_ip, tmac, tip};
    for (int i = 0; i < 28; i++) begin
      r = '0;
      r.kind = k;
      r.out_byte = pay[223 - 8*i -: 8];
      r.out_last = (i == 27);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void predict_request(input arp_pkg::in_item_t q);
    int                 s;
    arp_pkg::out_item_t r;
    logic [4:0]         pos;
    if (q.mode == arp_pkg::MODE_BYTE) begin
      pos = p_pos;
      if (pos < 8) p_hdr = {p_hdr[55:0], q.data_byte};
      else if (pos < 14) p_smac = {p_smac[39:0], q.data_byte};
      else if (pos < 18) p_sip = {p_sip[23:0], q.data_byte};
      else if (pos >= 24 && pos < 28) p_tip = {p_tip[23:0], q.data_byte};
      if (pos < 28) p_pos = pos + 5'd1;
      if (pos == 27 && p_hdr[63:16] == arp_pkg::HDR_OK) begin
        s = slot_of(p_sip);
        if (s < 0) begin
          s = victim;
          victim = (victim + 1) % NUM_SLOTS;
        end
        c_ip[s] = p_sip;
        c_mac[s] = p_smac;
        c_val[s] = 1'b1;
        if (p_hdr[15:0] == 16'd1 && p_tip == p_own_ip && p_tx_en)
          queue_payload(16'd2, p_smac, p_sip, arp_pkg::KIND_REPLY);
      end
      if (q.last_byte) p_pos = '0;
    end else if (q.mode == arp_pkg::MODE_LOOKUP) begin
      s = slot_of(q.query_ip);
      r = '0;
      r.kind = arp_pkg::KIND_ANSWER;
      r.out_last = 1'b1;
      r.answer_hit = (s >= 0);
      r.answer_mac = (s >= 0) ? c_mac[s] : '0;
      pending_results.push_back(r);
    end else if (q.mode == arp_pkg::MODE_SEND) begin
      if (p_tx_en) queue_payload(16'd1, 48'd0, q.query_ip, arp_pkg::KIND_REQ);
    end
  endfunction

  // Output side: random stall and check against the oldest expectation.
  initial begin
    arp_pkg::out_item_t got;
    arp_pkg::out_item_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(got), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind != want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
          if (got.out_byte != want.out_byte)
            report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
          if (got.out_last != want.out_last)
            report_mismatch("out_last", 64'(got.out_last), 64'(want.out_last));
          if (got.answer_mac != want.answer_mac)
            report_mismatch("answer_mac", 64'(got.answer_mac), 64'(want.answer_mac));
          if (got.answer_hit != want.answer_hit)
            report_mismatch("answer_hit", 64'(got.answer_hit), 64'(want.answer_hit));
        end
      end
    end
  end

  // Drives one request, idling first at random, and waits for acceptance.
  task automatic push_request(input arp_pkg::in_item_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = q;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(q);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      arp_pkg::REG_OWN_IP:  p_own_ip = val[31:0];
      arp_pkg::REG_OWN_MAC: p_own_mac = val;
      arp_pkg::REG_TX_EN:   p_tx_en = val[0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic arp_pkg::in_item_t byte_req(input logic [7:0] b, input logic lst);
    arp_pkg::in_item_t q;
    q = '0;
    q.mode = arp_pkg::MODE_BYTE;
    q.data_byte = b;
    q.last_byte = lst;
    q.query_ip = $urandom;
    return q;
  endfunction

  function automatic arp_pkg::in_item_t ip_req(input logic [1:0] m, input logic [31:0] ip);
    arp_pkg::in_item_t q;
    q = '0;
    q.mode = m;
    q.query_ip = ip;
    q.data_byte = 8'($urandom);
    q.last_byte = 1'($urandom);
    return q;
  endfunction

  // Sends one ARP frame; bad is 0 for a well-formed header, len over 28 adds trailing bytes.
  task automatic send_frame(input logic [15:0] op, input logic [47:0] smac,
                            input logic [31:0] sip, input logic [31:0] tip,
                            input int len, input bit bad, input int noise);
    logic [223:0] pay;
    logic [7:0]   b;
    int           flip;
    pay = {arp_pkg::HDR_OK, op, smac, sip, 32'($urandom), 16'($urandom_range(65535)), tip};
    if (bad) begin
      flip = 223 - 8 * $urandom_range(5);
      pay[flip -: 8] ^= 8'(1 << $urandom_range(7));
    end
    for (int i = 0; i < len; i++) begin
      b = (i < 28) ? pay[223 - 8*i -: 8] : 8'($urandom);
      push_request(byte_req(b, i == len - 1));
      if (noise > 0 && $urandom_range(99) < noise)
        push_request(ip_req(2'($urandom_range(1, 3)), $urandom));
    end
  endtask

  task automatic random_phase(input int n_frames);
    logic [31:0] ips [8];
    int          k;
    for (int i = 0; i < 8; i++) ips[i] = $urandom;
    ips[0] = p_own_ip;
    for (int f = 0; f < n_frames; f++) begin
      k = $urandom_range(9);
      if (k < 5) begin
        send_frame($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2)),
                   {16'($urandom), 32'($urandom)}, ips[$urandom_range(7)],
                   $urandom_range(1) ? p_own_ip : ips[$urandom_range(7)],
                   $urandom_range(3) == 0 ? $urandom_range(29, 34) : 28,
                   $urandom_range(7) == 0, 10);
      end else if (k == 5) begin
        send_frame(16'd1, {16'($urandom), 32'($urandom)}, $urandom, p_own_ip,
                   $urandom_range(1, 27), 0, 0);
      end else if (k < 9) begin
        push_request(ip_req(arp_pkg::MODE_LOOKUP,
                            $urandom_range(3) ? ips[$urandom_range(7)] : $urandom));
      end else begin
        push_request(ip_req($urandom_range(1) ? arp_pkg::MODE_SEND : MODE_UNUSED,
                            $urandom));
      end
    end
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    errors = 0;
    send_idle_pct = 7;
    recv_idle_pct = 74;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    p_own_ip = '0; p_own_mac = '0; p_tx_en = 1'b0;
    p_pos = '0; p_hdr = '0; p_smac = '0; p_sip = '0; p_tip = '0;
    victim = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      c_val[i] = 1'b0; c_ip[i] = '0; c_mac[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: empty cache misses at the address extremes, unused mode,
    // send with transmit disabled.
    rw.has_known = 1'b1;
    rw.known = '{kind: arp_pkg::KIND_ANSWER, out_byte: 8'd0, out_last: 1'b1,
                 answer_mac: 48'd0, answer_hit: 1'b0};
    rw.req = ip_req(arp_pkg::MODE_LOOKUP, 32'h0);          rows.push_back(rw);
    rw.req = ip_req(arp_pkg::MODE_LOOKUP, 32'hFFFF_FFFF);  rows.push_back(rw);
    rw.has_known = 1'b0;
    rw.req = ip_req(MODE_UNUSED, 32'hFFFF_FFFF);            rows.push_back(rw);
    rw.req = ip_req(arp_pkg::MODE_SEND, 32'h0A00_0001);     rows.push_back(rw);
    foreach (rows[i]) begin
      if (rows[i].has_known) begin
        push_request(rows[i].req);
        void'(pending_results.pop_back());
        pending_results.push_back(rows[i].known);
      end else begin
        push_request(rows[i].req);
      end
    end
    drain_results();

    // Extreme register values, then frames: reply, padding, short, other opcode.
    write_reg(arp_pkg::REG_OWN_IP, 48'hFFFF_FFFF);
    write_reg(arp_pkg::REG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(arp_pkg::REG_TX_EN, 48'd1);
    send_frame(16'd1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32, 0, 0);
    send_frame(16'd1, 48'h0, 32'h0, 32'hFFFF_FFFF, 20, 0, 0);
    send_frame(16'd2, 48'h1234_5678_9ABC, 32'h0, 32'hFFFF_FFFF, 28, 0, 30);
    push_request(ip_req(arp_pkg::MODE_LOOKUP, 32'h0));
    push_request(ip_req(arp_pkg::MODE_SEND, 32'hFFFF_FFFF));
    // Sender holds off until every result has come.
    drain_results();

    write_reg(arp_pkg::REG_OWN_IP, 48'h0);
    write_reg(arp_pkg::REG_OWN_MAC, 48'h0);
    random_phase(4);
    drain_results();

    send_idle_pct = 74;
    recv_idle_pct = 7;
    write_reg(arp_pkg::REG_OWN_IP, 48'hC0A8_0001);
    write_reg(arp_pkg::REG_OWN_MAC, 48'h0200_0000_0001);
    random_phase(4);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(arp_pkg::REG_TX_EN, 48'd0);
    random_phase(3);
    drain_results();
    write_reg(arp_pkg::REG_TX_EN, 48'd1);
    write_reg(arp_pkg::REG_OWN_IP, {16'd0, 32'($urandom)});
    random_phase(3);
    drain_results();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
